/* rtl/core/fjcs_pkg.sv */
// Shared types, codes and register constants for the flash job controller.
`timescale 1ns / 1ps

package fjcs_pkg;

	localparam int unsigned LastSector = 7;

	localparam logic [1:0] FUNC_POLL  = 2'd0;
	localparam logic [1:0] FUNC_ERASE = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;

	localparam logic [2:0] RES_OK    = 3'd0;
	localparam logic [2:0] RES_BUSY  = 3'd1;
	localparam logic [2:0] RES_FAIL  = 3'd2;
	localparam logic [2:0] RES_WPROT = 3'd3;
	localparam logic [2:0] RES_ALIGN = 3'd4;

	localparam logic CFG_DRIVER_ENABLED = 1'b0;
	localparam logic CFG_TIMEOUT_LIMIT  = 1'b1;

	localparam logic [19:0] TIMEOUT_RESET = 20'd1000000;

	localparam logic [16:0] CR_PG        = 17'h00001;
	localparam logic [16:0] CR_SER       = 17'h00002;
	localparam logic [16:0] CR_SNB_MASK  = 17'h00078;
	localparam logic [16:0] CR_PSIZE_MSK = 17'h00300;
	localparam logic [16:0] CR_PSIZE_32  = 17'h00200;
	localparam logic [16:0] CR_STRT      = 17'h10000;

	localparam int unsigned SR_BSY_BIT = 16;
	localparam logic [8:0] SR_EOP    = 9'h001;
	localparam logic [8:0] SR_WRPERR = 9'h010;
	localparam logic [8:0] SR_PGERRS = 9'h0E2;
	localparam logic [8:0] SR_RDERR  = 9'h100;
	localparam logic [8:0] SR_ALL    = 9'h1F3;

	typedef struct packed {
		logic [1:0]  func;
		logic [16:0] status_word;
		logic [7:0]  sector;
		logic [31:0] address;
		logic [31:0] length;
		logic [31:0] data_word;
	} fjcs_req_t;

	typedef struct packed {
		logic [2:0]  job_result;
		logic [8:0]  status_clear_mask;
		logic [16:0] control_clear_mask;
		logic [16:0] control_set_mask;
		logic        flush_cache;
		logic        program_valid;
		logic [31:0] program_address;
		logic [31:0] program_data;
	} fjcs_result_t;

endpackage

/* rtl/core/fjcs_decode.sv */
// Job decode: turns one request and the poll count into a result and the next count.
`timescale 1ns / 1ps

module fjcs_decode (
	input  fjcs_pkg::fjcs_req_t    req,
	input  logic                   driver_enabled,
	input  logic [19:0]            timeout_limit,
	input  logic [19:0]            busy_poll_count,
	output fjcs_pkg::fjcs_result_t result,
	output logic [19:0]            count_next
);
	import fjcs_pkg::*;

	logic        busy;
	logic [19:0] count_inc;
	logic [8:0]  sw_flags;

	assign busy      = req.status_word[SR_BSY_BIT];
	assign count_inc = busy_poll_count + 20'd1;
	assign sw_flags  = req.status_word[8:0];

	always_comb begin
		result     = '0;
		count_next = busy_poll_count;
		unique case (req.func)
			FUNC_POLL: begin
				if (busy) begin
					if (count_inc >= timeout_limit) begin
						count_next                = '0;
						result.job_result         = RES_FAIL;
						result.control_clear_mask = CR_PG | CR_SER | CR_STRT;
					end else begin
						count_next        = count_inc;
						result.job_result = RES_BUSY;
					end
				end else begin
					count_next = '0;
					priority if ((sw_flags & SR_RDERR) != '0) begin
						result.job_result         = RES_FAIL;
						result.status_clear_mask  = SR_RDERR;
						result.control_clear_mask = CR_PG | CR_SER;
					end else if ((sw_flags & SR_WRPERR) != '0) begin
						result.job_result         = RES_WPROT;
						result.status_clear_mask  = SR_WRPERR;
						result.control_clear_mask = CR_PG | CR_SER;
					end else if ((sw_flags & SR_PGERRS) != '0) begin
						result.job_result         = RES_ALIGN;
						result.status_clear_mask  = SR_PGERRS;
						result.control_clear_mask = CR_PG | CR_SER;
					end else if ((sw_flags & SR_EOP) != '0) begin
						result.job_result         = RES_OK;
						result.status_clear_mask  = SR_EOP;
						result.control_clear_mask = CR_PG | CR_SER;
						result.flush_cache        = 1'b1;
					end else begin
						result.job_result = RES_OK;
					end
				end
			end
			FUNC_ERASE: begin
				priority if (!driver_enabled || req.sector > 8'(LastSector)) begin
					result.job_result = RES_FAIL;
				end else if (busy) begin
					result.job_result = RES_BUSY;
				end else begin
					count_next                = '0;
					result.job_result         = RES_BUSY;
					result.status_clear_mask  = SR_ALL;
					result.control_clear_mask = CR_SNB_MASK | CR_PG;
					result.control_set_mask   = {10'd0, req.sector[3:0], 3'd0} | CR_SER | CR_STRT;
				end
			end
			FUNC_WRITE: begin
				priority if (!driver_enabled) begin
					result.job_result = RES_FAIL;
				end else if (req.address[1:0] != 2'd0 || req.length[1:0] != 2'd0
						|| req.length == 32'd0) begin
					result.job_result = RES_ALIGN;
				end else if (busy) begin
					result.job_result = RES_BUSY;
				end else begin
					count_next                = '0;
					result.job_result         = RES_BUSY;
					result.status_clear_mask  = SR_ALL;
					result.control_clear_mask = CR_PSIZE_MSK | CR_SER;
					result.control_set_mask   = CR_PSIZE_32 | CR_PG;
					result.program_valid      = 1'b1;
					result.program_address    = req.address;
					result.program_data       = req.data_word;
				end
			end
			default: begin
				result.job_result = RES_FAIL;
			end
		endcase
	end

endmodule

/* rtl/core/flash_job_control_and_status.sv */
// Top level of the flash job controller: input register, decode, result register.
`timescale 1ns / 1ps
// An accepted item is held in the input register, then its decoded result in the result register.
// One item per cycle unless stalled; the poll count updates as an item leaves the input register.
// A result register parts the two sides, so an empty input register takes an item while a result waits.
// Reset clears the valid flags and poll count, disables the driver and sets the timeout to 1000000.

module flash_job_control_and_status (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [16:0] status_word,
	input  logic [7:0]  sector,
	input  logic [31:0] address,
	input  logic [31:0] length,
	input  logic [31:0] data_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  job_result,
	output logic [8:0]  status_clear_mask,
	output logic [16:0] control_clear_mask,
	output logic [16:0] control_set_mask,
	output logic        flush_cache,
	output logic        program_valid,
	output logic [31:0] program_address,
	output logic [31:0] program_data
);
	import fjcs_pkg::*;

	logic         driver_enabled_q;
	logic [19:0]  timeout_limit_q;
	logic [19:0]  busy_poll_count_q;
	logic         valid_s1;
	fjcs_req_t    req_s1;
	logic         valid_s2;
	fjcs_result_t result_s2;
	fjcs_result_t result_d;
	logic [19:0]  count_next;
	logic         adv_s2;
	logic         adv_s1;

	assign cfg_ready = 1'b1;
	assign adv_s2    = !valid_s2 || !out_stall;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign in_stall  = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			driver_enabled_q <= 1'b0;
			timeout_limit_q  <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DRIVER_ENABLED: driver_enabled_q <= cfg_data[0];
				CFG_TIMEOUT_LIMIT:  timeout_limit_q  <= cfg_data;
				default:            driver_enabled_q <= driver_enabled_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			req_s1.func        <= func;
			req_s1.status_word <= status_word;
			req_s1.sector      <= sector;
			req_s1.address     <= address;
			req_s1.length      <= length;
			req_s1.data_word   <= data_word;
		end
	end

	fjcs_decode u_decode (
		.req             (req_s1),
		.driver_enabled  (driver_enabled_q),
		.timeout_limit   (timeout_limit_q),
		.busy_poll_count (busy_poll_count_q),
		.result          (result_d),
		.count_next      (count_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2          <= 1'b0;
			busy_poll_count_q <= '0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				busy_poll_count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_d;
		end
	end

	assign out_valid          = valid_s2;
	assign job_result         = result_s2.job_result;
	assign status_clear_mask  = result_s2.status_clear_mask;
	assign control_clear_mask = result_s2.control_clear_mask;
	assign control_set_mask   = result_s2.control_set_mask;
	assign flush_cache        = result_s2.flush_cache;
	assign program_valid      = result_s2.program_valid;
	assign program_address    = result_s2.program_address;
	assign program_data       = result_s2.program_data;

endmodule

/* tb/flash_job_control_and_status_test.sv */
// Self-checking testbench for the flash job controller with its own job predictor.
`timescale 1ns / 1ps

module flash_job_control_and_status_test;
	import fjcs_pkg::*;

	localparam logic [1:0]  FUNC_UNUSED = 2'd3;
	localparam logic [16:0] SW_BUSY     = 17'd1 << SR_BSY_BIT;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_index = 1'b0;
	logic [19:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        out_stall = 1'b0;
	fjcs_req_t   req_now   = '0;

	logic        cfg_ready;
	logic        in_stall;
	logic        out_valid;
	logic [2:0]  job_result;
	logic [8:0]  status_clear_mask;
	logic [16:0] control_clear_mask;
	logic [16:0] control_set_mask;
	logic        flush_cache;
	logic        program_valid;
	logic [31:0] program_address;
	logic [31:0] program_data;

	fjcs_req_t    pending_jobs [$];
	fjcs_result_t results_due [$];

	logic        drv_enabled = 1'b0;
	logic [19:0] poll_limit  = TIMEOUT_RESET;
	logic [19:0] poll_count  = '0;

	int n_queued       = 0;
	int n_results      = 0;
	int fault_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	flash_job_control_and_status u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.func               (req_now.func),
		.status_word        (req_now.status_word),
		.sector             (req_now.sector),
		.address            (req_now.address),
		.length             (req_now.length),
		.data_word          (req_now.data_word),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.job_result         (job_result),
		.status_clear_mask  (status_clear_mask),
		.control_clear_mask (control_clear_mask),
		.control_set_mask   (control_set_mask),
		.flush_cache        (flush_cache),
		.program_valid      (program_valid),
		.program_address    (program_address),
		.program_data       (program_data)
	);

	always #5 clk = ~clk;

	function automatic fjcs_result_t predict_job(fjcs_req_t r);
		fjcs_result_t e;
		logic         busy;
		logic [8:0]   flags;
		e = '0;
		busy = r.status_word[SR_BSY_BIT];
		flags = r.status_word[8:0];
		case (r.func)
			FUNC_POLL: begin
				if (busy) begin
					poll_count = poll_count + 20'd1;
					if (poll_count >= poll_limit) begin
						poll_count = '0;
						e.job_result = RES_FAIL;
						e.control_clear_mask = CR_PG | CR_SER | CR_STRT;
					end else begin
						e.job_result = RES_BUSY;
					end
				end else begin
					poll_count = '0;
					e.job_result = RES_OK;
					if ((flags & SR_RDERR) != 0) begin
						e.job_result = RES_FAIL;
						e.status_clear_mask = SR_RDERR;
					end else if ((flags & SR_WRPERR) != 0) begin
						e.job_result = RES_WPROT;
						e.status_clear_mask = SR_WRPERR;
					end else if ((flags & SR_PGERRS) != 0) begin
						e.job_result = RES_ALIGN;
						e.status_clear_mask = SR_PGERRS;
					end else if ((flags & SR_EOP) != 0) begin
						e.status_clear_mask = SR_EOP;
						e.flush_cache = 1'b1;
					end
					if (e.status_clear_mask != 0)
						e.control_clear_mask = CR_PG | CR_SER;
				end
			end
			FUNC_ERASE: begin
				if (!drv_enabled || r.sector > LastSector) begin
					e.job_result = RES_FAIL;
				end else if (busy) begin
					e.job_result = RES_BUSY;
				end else begin
					poll_count = '0;
					e.job_result = RES_BUSY;
					e.status_clear_mask = SR_ALL;
					e.control_clear_mask = CR_SNB_MASK | CR_PG;
					e.control_set_mask = {10'd0, r.sector[3:0], 3'd0} | CR_SER | CR_STRT;
				end
			end
			FUNC_WRITE: begin
				if (!drv_enabled) begin
					e.job_result = RES_FAIL;
				end else if (r.address[1:0] != 0 || r.length[1:0] != 0 || r.length == 0) begin
					e.job_result = RES_ALIGN;
				end else if (busy) begin
					e.job_result = RES_BUSY;
				end else begin
					poll_count = '0;
					e.job_result = RES_BUSY;
					e.status_clear_mask = SR_ALL;
					e.control_clear_mask = CR_PSIZE_MSK | CR_SER;
					e.control_set_mask = CR_PSIZE_32 | CR_PG;
					e.program_valid = 1'b1;
					e.program_address = r.address;
					e.program_data = r.data_word;
				end
			end
			default: begin
				e.job_result = RES_FAIL;
			end
		endcase
		return e;
	endfunction

	task automatic report_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin : feeder
		fjcs_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				results_due.push_back(predict_job(req_now));
			if (!in_valid || !in_stall) begin
				if (pending_jobs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_jobs.pop_front();
					req_now <= nxt;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin : result_check
		fjcs_result_t seen;
		fjcs_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen.job_result = job_result;
			seen.status_clear_mask = status_clear_mask;
			seen.control_clear_mask = control_clear_mask;
			seen.control_set_mask = control_set_mask;
			seen.flush_cache = flush_cache;
			seen.program_valid = program_valid;
			seen.program_address = program_address;
			seen.program_data = program_data;
			n_results++;
			if (results_due.size() == 0) begin
				report_fault($sformatf("result %0d arrived with nothing expected", n_results));
			end else begin
				want = results_due.pop_front();
				if (seen !== want)
					report_fault($sformatf({"result %0d mismatch (expected/actual): ",
						"job %0d/%0d sclr %h/%h cclr %h/%h cset %h/%h flush %b/%b ",
						"pv %b/%b pa %h/%h pd %h/%h"}, n_results,
						want.job_result, seen.job_result,
						want.status_clear_mask, seen.status_clear_mask,
						want.control_clear_mask, seen.control_clear_mask,
						want.control_set_mask, seen.control_set_mask,
						want.flush_cache, seen.flush_cache,
						want.program_valid, seen.program_valid,
						want.program_address, seen.program_address,
						want.program_data, seen.program_data));
			end
		end
	end

	task automatic queue_item(logic [1:0] f, logic [16:0] sw, logic [7:0] sec,
			logic [31:0] a, logic [31:0] l, logic [31:0] d);
		fjcs_req_t r;
		r.func = f;
		r.status_word = sw;
		r.sector = sec;
		r.address = a;
		r.length = l;
		r.data_word = d;
		pending_jobs.push_back(r);
		n_queued++;
	endtask

	task automatic settle();
		do @(posedge clk); while (n_results < n_queued);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [19:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_DRIVER_ENABLED)
			drv_enabled = val[0];
		else
			poll_limit = val;
	endtask

	task automatic random_items(int count);
		int          start_n;
		int          k;
		logic [31:0] a, l, d, w;
		logic [7:0]  sec;
		start_n = n_queued;
		while (n_queued - start_n < count) begin
			a = $urandom;
			l = $urandom;
			d = $urandom;
			w = $urandom;
			sec = 8'($urandom_range(LastSector));
			if ($urandom_range(99) < 75) begin
				if ($urandom_range(1) == 0) begin
					queue_item(FUNC_ERASE, w[16:0] & ~SW_BUSY, sec, a, l, d);
				end else begin
					a[1:0] = 2'b00;
					l[1:0] = 2'b00;
					if (l == 0)
						l = 32'd4;
					queue_item(FUNC_WRITE, w[16:0] & ~SW_BUSY, sec, a, l, d);
				end
				k = $urandom_range(6);
				repeat (k) begin
					w = $urandom;
					queue_item(FUNC_POLL, w[16:0] | SW_BUSY, sec, a, l, d);
				end
				w = $urandom;
				if ($urandom_range(1) == 0)
					w[8:0] = (w[8:0] & ~SR_ALL) | SR_EOP;
				queue_item(FUNC_POLL, w[16:0] & ~SW_BUSY, sec, a, l, d);
			end else begin
				if ($urandom_range(1) == 0)
					sec = 8'($urandom);
				if ($urandom_range(1) == 0) begin
					a[1:0] = 2'b00;
					l[1:0] = 2'b00;
				end
				queue_item(2'($urandom_range(3)), w[16:0], sec, a, l, d);
			end
		end
	endtask

	initial begin : stimulus
		logic        en;
		logic [19:0] lim;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: driver disabled, so erase and write are refused.
		queue_item(FUNC_ERASE, 17'd0, 8'd3, 32'd0, 32'd4, 32'd0);
		queue_item(FUNC_WRITE, 17'd0, 8'd0, 32'h100, 32'd4, 32'h1234);
		queue_item(FUNC_POLL, SW_BUSY, 8'd0, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_POLL, {8'd0, SR_EOP}, 8'd0, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_UNUSED, 17'h1FFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		settle();

		write_reg(CFG_DRIVER_ENABLED, 20'd1);
		write_reg(CFG_TIMEOUT_LIMIT, 20'd3);
		queue_item(FUNC_POLL, 17'd0, 8'd0, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_POLL, {8'd0, SR_EOP}, 8'd0, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_POLL, {8'd0, SR_ALL}, 8'd0, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_POLL, {8'd0, SR_WRPERR | SR_PGERRS | SR_EOP}, 8'd0, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_POLL, 17'h00081, 8'd0, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_POLL, 17'h00002, 8'd0, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_POLL, 17'h0FE0C, 8'd0, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_ERASE, 17'd0, 8'd0, 32'd0, 32'd0, 32'd0);
		repeat (3) queue_item(FUNC_POLL, 17'h1FFFF, 8'd0, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_POLL, {8'd0, SR_EOP}, 8'd0, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_ERASE, SW_BUSY, 8'd7, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_ERASE, 17'd0, 8'd7, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_ERASE, 17'd0, 8'd8, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_ERASE, 17'd0, 8'hFF, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_WRITE, 17'd0, 8'd0, 32'hFFFFFFFC, 32'hFFFFFFFC, 32'hFFFFFFFF);
		queue_item(FUNC_WRITE, 17'd0, 8'd0, 32'h00000001, 32'd4, 32'hA5A5A5A5);
		queue_item(FUNC_WRITE, 17'd0, 8'd0, 32'h00000010, 32'd2, 32'hA5A5A5A5);
		queue_item(FUNC_WRITE, 17'd0, 8'd0, 32'h00000010, 32'd0, 32'hA5A5A5A5);
		queue_item(FUNC_WRITE, SW_BUSY, 8'd0, 32'h00000010, 32'd8, 32'h5A5A5A5A);
		queue_item(FUNC_UNUSED, 17'd0, 8'd0, 32'd0, 32'd0, 32'd0);
		repeat (2) queue_item(FUNC_POLL, SW_BUSY, 8'd0, 32'd0, 32'd0, 32'd0);
		queue_item(FUNC_POLL, 17'd0, 8'd0, 32'd0, 32'd0, 32'd0);
		repeat (3) queue_item(FUNC_POLL, SW_BUSY, 8'd0, 32'd0, 32'd0, 32'd0);
		settle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin en = 1'b1; lim = 20'd1; end
				1: begin en = 1'b1; lim = 20'd0; end
				2: begin en = 1'b0; lim = 20'd5; end
				3: begin en = 1'b1; lim = 20'hFFFFF; end
				4: begin en = 1'b1; lim = 20'($urandom_range(2, 8)); end
				default: begin en = 1'b1; lim = 20'd4; end
			endcase
			write_reg(CFG_DRIVER_ENABLED, {19'd0, en});
			write_reg(CFG_TIMEOUT_LIMIT, lim);
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 71; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 71; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			random_items(40);
			settle();
			random_items(40);
			settle();
		end

		if (results_due.size() != 0)
			report_fault($sformatf("%0d expected results never arrived", results_due.size()));
		if (fault_count == 0)
			$display("flash_job_control_and_status_test: clean");
		else
			$display("flash_job_control_and_status_test: errors");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("flash_job_control_and_status_test: errors");
		$finish;
	end

endmodule
